// ----- rtl/core/cidt_pkg.sv -----
package cidt_pkg;

   localparam int unsigned SLOTS_DEFAULT = 4096;
   localparam int unsigned ID_W = 32;
   localparam int unsigned ARG_W = 64;
   localparam int unsigned SLOT_FIELD_W = 12;
   localparam int unsigned CSR_IDX_W = 3;
   localparam int unsigned CSR_COUNT = 6;

   typedef enum logic [2:0] {
      ACT_SET_ONE   = 3'd0,
      ACT_SET_RE    = 3'd1,
      ACT_SET_ALL   = 3'd2,
      ACT_READ      = 3'd3,
      ACT_FORK      = 3'd4,
      ACT_EXIT      = 3'd5,
      ACT_SEED      = 3'd6,
      ACT_NONE      = 3'd7
   } action_type;

   typedef enum logic [2:0] {
      CSR_USER_REAL  = 3'd0,
      CSR_USER_EFF   = 3'd1,
      CSR_USER_SAVED = 3'd2,
      CSR_GROUP_REAL = 3'd3,
      CSR_GROUP_EFF  = 3'd4,
      CSR_GROUP_SAVED = 3'd5
   } csr_index_type;

   typedef enum logic [1:0] {
      ARG_TAKE = 2'd0,
      ARG_KEEP = 2'd1,
      ARG_BAD  = 2'd2
   } arg_class_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_READ,
      BK_WRITE
   } back_state_type;

   typedef struct packed {
      action_type              action;
      logic                    is_group;
      logic [SLOT_FIELD_W-1:0] slot;
      logic [SLOT_FIELD_W-1:0] child;
      logic                    bad;
      arg_class_type           c1;
      arg_class_type           c2;
      arg_class_type           c3;
      logic                    wide1;
      logic [ID_W-1:0]         v1;
      logic [ID_W-1:0]         v2;
      logic [ID_W-1:0]         v3;
   } cmd_type;

   function automatic arg_class_type classify(input logic [ARG_W-1:0] v);
      priority if (v[ARG_W-1:ID_W] == '0 && v[ID_W-1:0] != '1) return ARG_TAKE;
      else if (v[ARG_W-1:ID_W] == '0 || v == '1) return ARG_KEEP;
      else return ARG_BAD;
   endfunction

endpackage

// ----- rtl/core/cidt_front.sv -----
module cidt_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_start,
   output logic                          req_busy,
   input  logic [2:0]                    req_action,
   input  logic                          req_is_group,
   input  logic [cidt_pkg::SLOT_FIELD_W-1:0] req_process_slot,
   input  logic [cidt_pkg::SLOT_FIELD_W-1:0] req_child_slot,
   input  logic [cidt_pkg::ARG_W-1:0]    req_arg_first,
   input  logic [cidt_pkg::ARG_W-1:0]    req_arg_second,
   input  logic [cidt_pkg::ARG_W-1:0]    req_arg_third,
   output logic                          q_valid,
   output cidt_pkg::cmd_type             q_cmd,
   input  logic                          q_pop
);
   // two-entry queue
   cidt_pkg::cmd_type q_mem_ff [2];
   logic        wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0]  cnt_ff, cnt_in;
   cidt_pkg::cmd_type cmd;
   logic        push;

   always_comb begin
      cmd.action   = cidt_pkg::action_type'(req_action);
      cmd.is_group = req_is_group;
      cmd.slot     = req_process_slot;
      cmd.child    = req_child_slot;
      cmd.c1       = cidt_pkg::classify(req_arg_first);
      cmd.c2       = cidt_pkg::classify(req_arg_second);
      cmd.c3       = cidt_pkg::classify(req_arg_third);
      cmd.wide1    = req_arg_first[cidt_pkg::ARG_W-1:cidt_pkg::ID_W] != '0;
      cmd.v1       = req_arg_first[cidt_pkg::ID_W-1:0];
      cmd.v2       = req_arg_second[cidt_pkg::ID_W-1:0];
      cmd.v3       = req_arg_third[cidt_pkg::ID_W-1:0];
      unique case (cmd.action)
         cidt_pkg::ACT_SET_ONE: cmd.bad = cmd.wide1;
         cidt_pkg::ACT_SET_RE:  cmd.bad = cmd.c1 == cidt_pkg::ARG_BAD
                                       || cmd.c2 == cidt_pkg::ARG_BAD;
         cidt_pkg::ACT_SET_ALL: cmd.bad = cmd.c1 == cidt_pkg::ARG_BAD
                                       || cmd.c2 == cidt_pkg::ARG_BAD
                                       || cmd.c3 == cidt_pkg::ARG_BAD;
         default:               cmd.bad = 1'b0;
      endcase
   end

   assign req_busy = cnt_ff == 2'd2;
   assign push     = req_start && !req_busy;
   assign q_valid  = cnt_ff != 2'd0;
   assign q_cmd    = q_mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ (q_pop && q_valid);
      cnt_in    = cnt_ff + 2'(push) - 2'(q_pop && q_valid);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_mem_ff[wr_ptr_ff] <= cmd;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   a_cnt_max: assert property (@(posedge clock) disable iff (reset) cnt_ff <= 2'd2)
      else $error("queue overflow");
   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid) else $error("pop from empty queue");
   a_full_busy: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == 2'd2 |-> req_busy) else $error("full queue not busy");
endmodule

// ----- rtl/core/cidt_back.sv -----
module cidt_back #(
   parameter int unsigned PROCESS_SLOTS = cidt_pkg::SLOTS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     q_valid,
   input  cidt_pkg::cmd_type        q_cmd,
   output logic                     q_pop,
   input  logic [cidt_pkg::ID_W-1:0] base_ff [cidt_pkg::CSR_COUNT],
   output logic                     clearing,
   output logic                     rsp_valid,
   output logic                     rsp_status,
   output logic [cidt_pkg::ID_W-1:0] rsp_real_id,
   output logic [cidt_pkg::ID_W-1:0] rsp_effective_id,
   output logic [cidt_pkg::ID_W-1:0] rsp_saved_id
);
   localparam int unsigned AW = (PROCESS_SLOTS > 1) ? $clog2(PROCESS_SLOTS) : 1;
   localparam int unsigned ROW_W = 6 * cidt_pkg::ID_W;
   localparam int unsigned IW = cidt_pkg::ID_W;

   // one row: {gs, ge, gr, us, ue, ur}
   logic [ROW_W-1:0] mem [PROCESS_SLOTS];
   logic [ROW_W-1:0] rd_ff;
   logic [AW:0]      clr_ff, clr_in;
   cidt_pkg::back_state_type st_ff, st_in;
   cidt_pkg::cmd_type cmd_ff;
   logic [AW-1:0]    slot, child;
   logic             we, we2;
   logic [AW-1:0]    wa, wa2;
   logic [ROW_W-1:0] wd;
   logic [IW-1:0]    r, e, s, nr, ne, ns;
   logic [ROW_W-1:0] seed_row;

   assign clearing = !clr_ff[AW];
   assign slot  = AW'(cmd_ff.slot % PROCESS_SLOTS);
   assign child = AW'(cmd_ff.child % PROCESS_SLOTS);

   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         cidt_pkg::BK_IDLE:  if (q_valid && !clearing) st_in = cidt_pkg::BK_READ;
         cidt_pkg::BK_READ:  st_in = cidt_pkg::BK_WRITE;
         cidt_pkg::BK_WRITE: st_in = cidt_pkg::BK_IDLE;
         default:            st_in = cidt_pkg::BK_IDLE;
      endcase
   end

   assign q_pop = st_ff == cidt_pkg::BK_IDLE && q_valid && !clearing;
   assign clr_in = clearing ? clr_ff + 1'b1 : clr_ff;

   assign seed_row = {base_ff[cidt_pkg::CSR_GROUP_SAVED], base_ff[cidt_pkg::CSR_GROUP_EFF],
                      base_ff[cidt_pkg::CSR_GROUP_REAL], base_ff[cidt_pkg::CSR_USER_SAVED],
                      base_ff[cidt_pkg::CSR_USER_EFF], base_ff[cidt_pkg::CSR_USER_REAL]};

   always_comb begin
      r = cmd_ff.is_group ? rd_ff[3*IW +: IW] : rd_ff[0 +: IW];
      e = cmd_ff.is_group ? rd_ff[4*IW +: IW] : rd_ff[IW +: IW];
      s = cmd_ff.is_group ? rd_ff[5*IW +: IW] : rd_ff[2*IW +: IW];
      nr = r; ne = e; ns = s;
      unique case (cmd_ff.action)
         cidt_pkg::ACT_SET_ONE: begin
            ne = cmd_ff.v1;
            if (rd_ff[IW +: IW] == '0) begin
               nr = cmd_ff.v1;
               ns = cmd_ff.v1;
            end
         end
         cidt_pkg::ACT_SET_RE: begin
            if (cmd_ff.c2 == cidt_pkg::ARG_TAKE) begin
               ne = cmd_ff.v2;
               if (cmd_ff.v2 != r) ns = cmd_ff.v2;
            end
            if (cmd_ff.c1 == cidt_pkg::ARG_TAKE) begin
               nr = cmd_ff.v1;
               ns = ne;
            end
         end
         cidt_pkg::ACT_SET_ALL: begin
            if (cmd_ff.c1 == cidt_pkg::ARG_TAKE) nr = cmd_ff.v1;
            if (cmd_ff.c2 == cidt_pkg::ARG_TAKE) ne = cmd_ff.v2;
            if (cmd_ff.c3 == cidt_pkg::ARG_TAKE) ns = cmd_ff.v3;
         end
         cidt_pkg::ACT_EXIT: begin
            nr = '0; ne = '0; ns = '0;
         end
         cidt_pkg::ACT_SEED: begin
            nr = cmd_ff.is_group ? base_ff[cidt_pkg::CSR_GROUP_REAL]
                                 : base_ff[cidt_pkg::CSR_USER_REAL];
            ne = cmd_ff.is_group ? base_ff[cidt_pkg::CSR_GROUP_EFF]
                                 : base_ff[cidt_pkg::CSR_USER_EFF];
            ns = cmd_ff.is_group ? base_ff[cidt_pkg::CSR_GROUP_SAVED]
                                 : base_ff[cidt_pkg::CSR_USER_SAVED];
         end
         default: ;
      endcase
      if (cmd_ff.bad) begin
         nr = r; ne = e; ns = s;
      end
      wd = rd_ff;
      if (cmd_ff.action == cidt_pkg::ACT_SEED) wd = seed_row;
      else if (cmd_ff.action == cidt_pkg::ACT_EXIT) wd = '0;
      else if (cmd_ff.is_group) wd[3*IW +: 3*IW] = {ns, ne, nr};
      else wd[0 +: 3*IW] = {ns, ne, nr};
      we = 1'b0; wa = slot; we2 = 1'b0; wa2 = child;
      if (clearing) begin
         we = 1'b1;
         wa = clr_ff[AW-1:0];
         wd = '0;
      end else if (st_ff == cidt_pkg::BK_WRITE) begin
         we  = cmd_ff.action != cidt_pkg::ACT_READ && cmd_ff.action != cidt_pkg::ACT_NONE
            && cmd_ff.action != cidt_pkg::ACT_FORK && !cmd_ff.bad;
         we2 = cmd_ff.action == cidt_pkg::ACT_FORK || cmd_ff.action == cidt_pkg::ACT_SEED;
      end
   end

   // second write port used only for fork/seed child copy
   always_ff @(posedge clock) begin
      if (we) mem[wa] <= wd;
      if (we2 && !(we && wa == wa2)) mem[wa2] <= (cmd_ff.action == cidt_pkg::ACT_SEED)
                                                 ? seed_row : rd_ff;
      if (st_ff == cidt_pkg::BK_READ) rd_ff <= mem[slot];
      if (q_pop) cmd_ff <= q_cmd;
      rsp_status <= cmd_ff.bad;
      rsp_real_id <= nr;
      rsp_effective_id <= ne;
      rsp_saved_id <= ns;
      if (reset) begin
         st_ff     <= cidt_pkg::BK_IDLE;
         clr_ff    <= '0;
         rsp_valid <= 1'b0;
      end else begin
         st_ff     <= st_in;
         clr_ff    <= clr_in;
         rsp_valid <= st_ff == cidt_pkg::BK_WRITE && !clearing;
      end
   end

   a_rsp_after_write: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(st_ff) == cidt_pkg::BK_WRITE) else $error("stray response");
   a_no_pop_clear: assert property (@(posedge clock) disable iff (reset)
      clearing |-> !q_pop) else $error("pop during clear");
   a_seq: assert property (@(posedge clock) disable iff (reset)
      st_ff == cidt_pkg::BK_READ |=> st_ff == cidt_pkg::BK_WRITE) else $error("bad sequence");
endmodule

// ----- rtl/core/credential_id_table_top.sv -----
// Credential id table: real/effective/saved user and group ids per process slot.
// Requests: raise start with req_* fields while busy is low; a request
// is taken on that edge. busy rises when the two-entry queue is full and
// stays high after reset while the table is swept to zero (one row per cycle).
// Results: rsp_strobe pulses one cycle with status and the selected kind's
// ids; the receiver cannot stall, results are never held.
// Flow: a request waits in the queue while the back end works through an
// earlier one; the back end takes one request at a time through its idle,
// read and write steps on one table row (a second write port stores the
// child row on fork and seed).
// Configuration: csr_write_enable with csr_index 0..5 loads a base register;
// other indexes are ignored. Write only while idle.
// Reset: synchronous, active high; queue empty, base registers zero.
module credential_id_table_top #(
   parameter int unsigned PROCESS_SLOTS = cidt_pkg::SLOTS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic [2:0]                req_action,
   input  logic                      req_is_group,
   input  logic [11:0]               req_process_slot,
   input  logic [11:0]               req_child_slot,
   input  logic [63:0]               req_arg_first,
   input  logic [63:0]               req_arg_second,
   input  logic [63:0]               req_arg_third,
   output logic                      rsp_strobe,
   output logic                      rsp_status,
   output logic [31:0]               rsp_real_id,
   output logic [31:0]               rsp_effective_id,
   output logic [31:0]               rsp_saved_id,
   input  logic                      csr_write_enable,
   input  logic [2:0]                csr_index,
   input  logic [31:0]               csr_write_data
);
   logic [cidt_pkg::ID_W-1:0] base_ff [cidt_pkg::CSR_COUNT];
   logic              q_valid, q_pop, clearing, q_busy;
   cidt_pkg::cmd_type q_cmd;

   assign busy = q_busy || clearing;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < cidt_pkg::CSR_COUNT; i++) base_ff[i] <= '0;
      end else if (csr_write_enable
                   && csr_index <= 3'(cidt_pkg::CSR_GROUP_SAVED)) begin
         base_ff[csr_index] <= csr_write_data;
      end
   end

   cidt_front u_front (
      .clock, .reset,
      .req_start(start && !clearing), .req_busy(q_busy),
      .req_action, .req_is_group, .req_process_slot, .req_child_slot,
      .req_arg_first, .req_arg_second, .req_arg_third,
      .q_valid, .q_cmd, .q_pop
   );

   cidt_back #(.PROCESS_SLOTS(PROCESS_SLOTS)) u_back (
      .clock, .reset, .q_valid, .q_cmd, .q_pop, .base_ff, .clearing,
      .rsp_valid(rsp_strobe), .rsp_status, .rsp_real_id, .rsp_effective_id,
      .rsp_saved_id
   );
endmodule
